>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, operation codes and queue word type for the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int SCROLL_ROW = 23;

  localparam int NCELLS = COLS * ROWS;
  localparam int SROW   = (SCROLL_ROW < ROWS) ? SCROLL_ROW : ROWS - 1;
  localparam int SROWC  = SROW * COLS;

  // cell address width and width of the unclipped linear index
  localparam int AW    = $clog2(NCELLS);
  localparam int IDX_W = $clog2(255 * COLS + 512);

  localparam int CUR_W = 11;
  localparam int POS_W = 16;

  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_PUT_AT     = 3'd1;
  localparam logic [2:0] OP_FILL_RECT  = 3'd2;
  localparam logic [2:0] OP_CLEAR_SCR  = 3'd3;
  localparam logic [2:0] OP_CLEAR_CHAR = 3'd4;
  localparam logic [2:0] OP_SET_CURSOR = 3'd5;
  localparam logic [2:0] OP_READ_CELL  = 3'd6;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       ch;
    logic [7:0]       fattr;
    logic [7:0]       rw;
    logic [7:0]       rh;
    logic [IDX_W-1:0] lin;
    logic [POS_W-1:0] pos;
    logic             pos_ok;
  } item_t;

endpackage

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text screen of character/attribute cells with a write cursor.
// ----------------------------------------------------------------------------
// Each input word performs one screen operation and returns one result word.
// After reset the screen RAM is swept to zero before the first operation
// executes; up to two words are queued meanwhile. Set_cursor walks the
// rows to find the start of the cursor's row. A scroll reads and writes
// each moved cell and then zeroes the vacated row, clear_screen writes
// every cell, and fill_rect writes each cell of the rectangle, all through
// the single write port of the screen RAM. Configuration writes are
// always taken.
module text_console_writer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                text_attr,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                operation,
  input  logic [7:0]                character,
  input  logic [7:0]                col,
  input  logic [7:0]                row,
  input  logic [7:0]                rect_width,
  input  logic [7:0]                rect_height,
  input  logic [7:0]                fill_attr,
  input  logic [tcw_pkg::POS_W-1:0] position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tcw_pkg::CUR_W-1:0] cursor,
  output logic [7:0]                cell_char,
  output logic [7:0]                cell_attr,
  output logic                      out_of_range
);

  logic                   attr;
  logic [7:0]             attr_reg;
  logic                   q_valid;
  tcw_pkg::item_t         q_item;
  logic                   q_pop;
  logic                   ram_we;
  logic [tcw_pkg::AW-1:0] ram_waddr;
  logic [15:0]            ram_wdata;
  logic [tcw_pkg::AW-1:0] ram_raddr;
  logic [15:0]            ram_rdata;

  assign cfg_ready = 1'b1;
  assign attr      = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_reg <= tcw_pkg::ATTR_RESET;
    end else if (attr) begin
      attr_reg <= text_attr;
    end
  end

  tcw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .character   (character),
    .col         (col),
    .row         (row),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .fill_attr   (fill_attr),
    .position    (position),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (tcw_pkg::NCELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .text_attr    (attr_reg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor       (cursor),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input words, precomputes the linear index and range check, and
// holds them in a two entry queue for the execution side.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               operation,
  input  logic [7:0]               character,
  input  logic [7:0]               col,
  input  logic [7:0]               row,
  input  logic [7:0]               rect_width,
  input  logic [7:0]               rect_height,
  input  logic [7:0]               fill_attr,
  input  logic [tcw_pkg::POS_W-1:0] position,
  output logic                     q_valid,
  output tcw_pkg::item_t           q_item,
  input  logic                     q_pop
);

  tcw_pkg::item_t q [2];
  tcw_pkg::item_t item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    item.op     = operation;
    item.ch     = character;
    item.fattr  = fill_attr;
    item.rw     = rect_width;
    item.rh     = rect_height;
    item.lin    = tcw_pkg::IDX_W'(row) * tcw_pkg::IDX_W'(tcw_pkg::COLS)
                + tcw_pkg::IDX_W'(col);
    item.pos    = position;
    item.pos_ok = (32'(position) < tcw_pkg::NCELLS);
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes one queued operation at a time against the screen RAM: cell
// writes and reads, read-modify-write, cursor moves, scrolls, fills and
// clears, then posts the result word into an output register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                text_attr,
  input  logic                      q_valid,
  input  tcw_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      ram_we,
  output logic [tcw_pkg::AW-1:0]    ram_waddr,
  output logic [15:0]               ram_wdata,
  output logic [tcw_pkg::AW-1:0]    ram_raddr,
  input  logic [15:0]               ram_rdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tcw_pkg::CUR_W-1:0] cursor,
  output logic [7:0]                cell_char,
  output logic [7:0]                cell_attr,
  output logic                      out_of_range
);

  localparam int AW    = tcw_pkg::AW;
  localparam int IDX_W = tcw_pkg::IDX_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RMW   = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SC_RD = 4'd6;
  localparam logic [3:0] S_SC_WR = 4'd7;
  localparam logic [3:0] S_ZERO  = 4'd8;
  localparam logic [3:0] S_CLEAR = 4'd9;
  localparam logic [3:0] S_FILL  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]       state;
  tcw_pkg::item_t   cur;
  logic [AW-1:0]    cur_pos;
  logic [AW-1:0]    line;
  logic [AW-1:0]    cnt;
  logic [IDX_W-1:0] base;
  logic [7:0]       i;
  logic [7:0]       j;
  logic             oor;
  logic [7:0]       rc;
  logic [7:0]       ra;
  logic [AW:0]      cur_inc;
  logic [AW:0]      line_inc;
  logic [IDX_W-1:0] fidx;
  logic             fidx_ok;
  logic             lin_ok;

  assign cur_inc  = {1'b0, cur_pos} + (AW+1)'(1);
  assign line_inc = {1'b0, line} + (AW+1)'(tcw_pkg::COLS);
  assign fidx     = base + IDX_W'(j);
  assign fidx_ok  = (32'(fidx) < tcw_pkg::NCELLS);
  assign lin_ok   = (32'(cur.lin) < tcw_pkg::NCELLS);
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = 16'h0000;
    ram_raddr = cnt + AW'(tcw_pkg::COLS);
    case (state)
      S_INIT, S_ZERO: begin
        ram_we = 1'b1;
      end
      S_DISP: begin
        ram_raddr = AW'(cur.pos);
        if (cur.op == tcw_pkg::OP_PUT_CHAR && cur.ch != tcw_pkg::CH_NEWLINE) begin
          ram_we    = 1'b1;
          ram_waddr = cur_pos;
          ram_wdata = {text_attr, cur.ch};
        end else if (cur.op == tcw_pkg::OP_PUT_AT && lin_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cur.lin);
          ram_wdata = {text_attr, cur.ch};
        end
      end
      S_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur.pos);
        ram_wdata = {ram_rdata[15:8], tcw_pkg::CH_BLANK};
      end
      S_SC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {text_attr, tcw_pkg::CH_BLANK};
      end
      S_FILL: begin
        ram_we    = fidx_ok;
        ram_waddr = AW'(fidx);
        ram_wdata = {cur.fattr, tcw_pkg::CH_BLANK};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      cur_pos   <= '0;
      line      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (cnt == AW'(tcw_pkg::NCELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            oor   <= 1'b0;
            rc    <= 8'h00;
            ra    <= 8'h00;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (cur.op)
            tcw_pkg::OP_PUT_CHAR: begin
              if (cur.ch == tcw_pkg::CH_NEWLINE) begin
                if (32'(line) >= tcw_pkg::SROWC) begin
                  cur_pos <= AW'(tcw_pkg::SROWC);
                  line    <= AW'(tcw_pkg::SROWC);
                  cnt     <= '0;
                  state   <= S_SC_RD;
                end else begin
                  cur_pos <= AW'(line_inc);
                  line    <= AW'(line_inc);
                  state   <= S_DONE;
                end
              end else if (32'(cur_inc) >= tcw_pkg::SROWC + tcw_pkg::COLS) begin
                cur_pos <= AW'(tcw_pkg::SROWC);
                line    <= AW'(tcw_pkg::SROWC);
                cnt     <= '0;
                state   <= S_SC_RD;
              end else begin
                cur_pos <= AW'(cur_inc);
                if (cur_inc == line_inc) begin
                  line <= AW'(line_inc);
                end
                state <= S_DONE;
              end
            end
            tcw_pkg::OP_PUT_AT: begin
              oor   <= !lin_ok;
              state <= S_DONE;
            end
            tcw_pkg::OP_FILL_RECT: begin
              if (cur.rw != 8'd0 && cur.rh != 8'd0) begin
                base  <= cur.lin;
                i     <= 8'd0;
                j     <= 8'd0;
                state <= S_FILL;
              end else begin
                state <= S_DONE;
              end
            end
            tcw_pkg::OP_CLEAR_SCR: begin
              cnt     <= '0;
              cur_pos <= '0;
              line    <= '0;
              state   <= S_CLEAR;
            end
            tcw_pkg::OP_CLEAR_CHAR: begin
              if (cur.pos_ok) begin
                state <= S_RMW;
              end else begin
                oor   <= 1'b1;
                state <= S_DONE;
              end
            end
            tcw_pkg::OP_SET_CURSOR: begin
              line <= '0;
              if (cur.pos_ok) begin
                cur_pos <= AW'(cur.pos);
                state   <= S_DIV;
              end else begin
                cur_pos <= '0;
                oor     <= 1'b1;
                state   <= S_DONE;
              end
            end
            tcw_pkg::OP_READ_CELL: begin
              if (cur.pos_ok) begin
                state <= S_READ;
              end else begin
                oor   <= 1'b1;
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RMW: begin
          state <= S_DONE;
        end
        S_READ: begin
          rc    <= ram_rdata[7:0];
          ra    <= ram_rdata[15:8];
          state <= S_DONE;
        end
        S_DIV: begin
          // find the start of the cursor's row by stepping one row a cycle
          if (line_inc <= {1'b0, cur_pos}) begin
            line <= AW'(line_inc);
          end else begin
            state <= S_DONE;
          end
        end
        S_SC_RD: begin
          state <= S_SC_WR;
        end
        S_SC_WR: begin
          if (cnt == AW'(tcw_pkg::SROWC - 1)) begin
            cnt   <= AW'(tcw_pkg::SROWC);
            state <= S_ZERO;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= S_SC_RD;
          end
        end
        S_ZERO: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(tcw_pkg::SROWC + tcw_pkg::COLS - 1)) begin
            state <= S_DONE;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(tcw_pkg::NCELLS - 1)) begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          if (!fidx_ok) begin
            oor <= 1'b1;
          end
          // rest of a row past the buffer end is out too; a row that starts
          // past it ends the fill
          if (!fidx_ok && j == 8'd0) begin
            state <= S_DONE;
          end else if (!fidx_ok || j == cur.rw - 8'd1) begin
            j    <= 8'd0;
            base <= base + IDX_W'(tcw_pkg::COLS);
            if (i == cur.rh - 8'd1) begin
              state <= S_DONE;
            end else begin
              i <= i + 8'd1;
            end
          end else begin
            j <= j + 8'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            cursor       <= tcw_pkg::CUR_W'(cur_pos);
            cell_char    <= rc;
            cell_attr    <= ra;
            out_of_range <= oor;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_pos) < tcw_pkg::NCELLS)
    else $error("cursor outside the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(ram_waddr) < tcw_pkg::NCELLS)
    else $error("ram write outside the screen");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (line <= cur_pos) && (32'(cur_pos - line) < tcw_pkg::COLS))
    else $error("row start does not match cursor");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_DISP)
    else $error("queue popped outside idle");

endmodule
